// File: rtl/dro_pkg.sv
// Shared constants, job type and font table for the decimal reading renderer.
`default_nettype none

package dro_pkg;

  // Number of decimal digits drawn for each reading.
  localparam int DIGIT_COUNT = 4;
  // Digits, then the degree sign and the capital C.
  localparam int GLYPH_COUNT = DIGIT_COUNT + 2;
  // One cursor and one data transaction for every glyph.
  localparam int STEP_COUNT  = 2 * GLYPH_COUNT;
  localparam int STEP_W      = $clog2(STEP_COUNT);
  localparam int GIDX_W      = STEP_W - 1;
  localparam int DIG_CNT_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // Fixed field widths.
  localparam int READING_W = 16;
  localparam int COLUMN_W  = 8;
  localparam int PAGE_W    = 4;
  localparam int DIGIT_W   = 4;

  // Division by ten of a 16-bit value: q = (v * 52429) >> 19.
  localparam int          RECIP_W     = 17;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [16:0] RECIP_TEN   = 17'd52429;
  localparam int          PROD_W      = READING_W + RECIP_W;

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Transaction bytes and codes.
  localparam logic [7:0]   ADDR_RESET   = 8'h78;
  localparam logic [7:0]   CTRL_CMD     = 8'h00;
  localparam logic [7:0]   CTRL_DATA    = 8'h40;
  localparam logic [7:0]   CMD_COL_HI   = 8'h10;
  localparam logic [7:0]   CMD_PAGE     = 8'hB0;
  localparam logic [3:0]   COUNT_CURSOR = 4'd5;
  localparam logic [3:0]   COUNT_DATA   = 4'd8;
  localparam logic [DIGIT_W-1:0] GLYPH_DEGREE  = 4'd10;
  localparam logic [DIGIT_W-1:0] GLYPH_CELSIUS = 4'd11;

  // One reading after digit extraction; digits[k] is the k-th digit from the left.
  typedef struct packed {
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits;
    logic [COLUMN_W-1:0]                 column;
    logic [PAGE_W-1:0]                   page;
  } job_t;

  // Six font columns of a glyph, column 0 in the top byte.
  function automatic logic [47:0] glyph_row(input logic [DIGIT_W-1:0] code);
    logic [47:0] row;
    case (code)
      4'd0:    row = 48'h3E_51_49_45_3E_00;
      4'd1:    row = 48'h00_42_7F_40_00_00;
      4'd2:    row = 48'h72_49_49_49_46_00;
      4'd3:    row = 48'h21_41_49_4D_33_00;
      4'd4:    row = 48'h18_14_12_7F_10_00;
      4'd5:    row = 48'h27_45_45_45_39_00;
      4'd6:    row = 48'h3C_4A_49_49_31_00;
      4'd7:    row = 48'h41_21_11_09_07_00;
      4'd8:    row = 48'h36_49_49_49_36_00;
      4'd9:    row = 48'h46_49_49_29_1E_00;
      4'd10:   row = 48'h00_06_09_06_00_00;
      4'd11:   row = 48'h3E_41_41_41_22_00;
      default: row = 48'h0;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dro_front.sv
// Front end: accepts readings and extracts the decimal digits, one per cycle.
`default_nettype none

module dro_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [dro_pkg::READING_W-1:0]    reading,
  input  wire  [dro_pkg::COLUMN_W-1:0]     start_column,
  input  wire  [dro_pkg::PAGE_W-1:0]       page,
  output logic                             push,
  output dro_pkg::job_t                    push_job,
  input  wire                              push_ready
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t                                    state, state_next;
  logic [dro_pkg::READING_W-1:0]                   value;
  logic [dro_pkg::DIG_CNT_W-1:0]                   cnt;
  logic [dro_pkg::DIGIT_COUNT-1:0][dro_pkg::DIGIT_W-1:0] digits, digits_next;
  logic [dro_pkg::COLUMN_W-1:0]                    column;
  logic [dro_pkg::PAGE_W-1:0]                      pg;
  logic [dro_pkg::PROD_W-1:0]                      prod;
  logic [dro_pkg::READING_W-1:0]                   quot;
  logic [dro_pkg::READING_W-1:0]                   rem;
  logic                                            load;

  // Quotient by ten through the reciprocal, remainder by shift and add.
  assign prod = dro_pkg::PROD_W'(value) * dro_pkg::PROD_W'(dro_pkg::RECIP_TEN);
  assign quot = dro_pkg::READING_W'(prod >> dro_pkg::RECIP_SHIFT);
  assign rem  = value - ((quot << 3) + (quot << 1));

  // The lowest digit comes out first and moves up to the rightmost place.
  always_comb begin
    for (int i = 0; i < dro_pkg::DIGIT_COUNT; i++) begin
      if (i == 0) begin
        digits_next[i] = rem[dro_pkg::DIGIT_W-1:0];
      end else begin
        digits_next[i] = digits[i-1];
      end
    end
  end

  // A new request is taken when idle or as the finished one leaves.
  assign in_ready = (state == F_IDLE) || ((state == F_PUSH) && push_ready);
  assign load     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_valid) state_next = F_CONV;
      end
      F_CONV: begin
        if (cnt == dro_pkg::DIG_CNT_W'(dro_pkg::DIGIT_COUNT - 1)) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_next = in_valid ? F_CONV : F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the conversion.
  always_ff @(posedge clk) begin
    if (load) begin
      value  <= reading;
      column <= start_column;
      pg     <= page;
      cnt    <= '0;
    end else if (state == F_CONV) begin
      value  <= quot;
      digits <= digits_next;
      cnt    <= cnt + 1'b1;
    end
  end

  assign push            = (state == F_PUSH);
  assign push_job.digits = digits;
  assign push_job.column = column;
  assign push_job.page   = pg;

endmodule

`default_nettype wire

// File: rtl/dro_queue.sv
// Short queue of converted readings between the front and the back.
`default_nettype none

module dro_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  dro_pkg::job_t  push_job,
  output logic           push_ready,
  output logic           head_valid,
  output dro_pkg::job_t  head_job,
  input  wire            pop
);

  dro_pkg::job_t               store [dro_pkg::QUEUE_DEPTH];
  logic [dro_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [dro_pkg::QCNT_W-1:0]  count;
  logic                        do_push, do_pop;

  assign push_ready = (count != dro_pkg::QCNT_W'(dro_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = store[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_INC(do_push) - QCNT_INC(do_pop);
    end
  end

  function automatic logic [dro_pkg::QCNT_W-1:0] QCNT_INC(input logic b);
    return {{(dro_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

// File: rtl/dro_back.sv
// Back end: steps through the cursor and data transactions of each reading.
`default_nettype none

module dro_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    head_valid,
  input  dro_pkg::job_t          head_job,
  output logic                   pop,
  input  wire  [7:0]             address,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   is_data,
  output logic [3:0]             byte_count,
  output logic [7:0]             byte_zero,
  output logic [7:0]             byte_one,
  output logic [7:0]             byte_two,
  output logic [7:0]             byte_three,
  output logic [7:0]             byte_four,
  output logic [7:0]             byte_five,
  output logic [7:0]             byte_six,
  output logic [7:0]             byte_seven,
  output logic                   last
);

  logic [dro_pkg::STEP_W-1:0]    step;
  logic [dro_pkg::GIDX_W-1:0]    gidx;
  logic                          advance;
  logic                          step_end;
  logic [dro_pkg::DIGIT_W-1:0]   code;
  logic [47:0]                   row;
  logic [7:0]                    col;

  assign gidx     = step[dro_pkg::STEP_W-1:1];
  assign advance  = head_valid && (!out_valid || out_ready);
  assign step_end = (step == dro_pkg::STEP_W'(dro_pkg::STEP_COUNT - 1));
  assign pop      = advance && step_end;

  // Glyph chosen by the position within the reading.
  always_comb begin
    if (gidx < dro_pkg::GIDX_W'(dro_pkg::DIGIT_COUNT)) begin
      code = head_job.digits[gidx[dro_pkg::DIG_CNT_W-1:0]];
    end else if (gidx == dro_pkg::GIDX_W'(dro_pkg::DIGIT_COUNT)) begin
      code = dro_pkg::GLYPH_DEGREE;
    end else begin
      code = dro_pkg::GLYPH_CELSIUS;
    end
  end

  assign row = dro_pkg::glyph_row(code);
  assign col = head_job.column + 8'({gidx, 3'b000});

  // Step counter over the transactions of the head request.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (advance) begin
      step <= step_end ? '0 : step + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_data   <= step[0];
      byte_zero <= address;
      last      <= step_end;
      if (step[0]) begin
        byte_count <= dro_pkg::COUNT_DATA;
        byte_one   <= dro_pkg::CTRL_DATA;
        byte_two   <= row[47:40];
        byte_three <= row[39:32];
        byte_four  <= row[31:24];
        byte_five  <= row[23:16];
        byte_six   <= row[15:8];
        byte_seven <= row[7:0];
      end else begin
        byte_count <= dro_pkg::COUNT_CURSOR;
        byte_one   <= dro_pkg::CTRL_CMD;
        byte_two   <= {4'h0, col[3:0]};
        byte_three <= dro_pkg::CMD_COL_HI | {4'h0, col[7:4]};
        byte_four  <= dro_pkg::CMD_PAGE | {4'h0, head_job.page};
        byte_five  <= 8'h00;
        byte_six   <= 8'h00;
        byte_seven <= 8'h00;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> is_data)
    else $error("last flag on a cursor transaction");
  a_count_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_data ? byte_count == dro_pkg::COUNT_DATA
                           : byte_count == dro_pkg::COUNT_CURSOR))
    else $error("byte count does not match transaction kind");
  a_pop_restarts: assert property (@(posedge clk) disable iff (rst)
    pop |=> step == '0)
    else $error("step counter not restarted after the last transaction");
  a_pop_flags_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && last)
    else $error("request retired without its final transaction");
`endif

endmodule

`default_nettype wire

// File: rtl/decimal_reading_oled_renderer.sv
// Top level of the decimal reading renderer for a page-addressed OLED on I2C.
// Each accepted reading yields twelve transactions: a cursor and a data transaction for each of
// four decimal digits, a degree sign and a C. Transactions leave at one per cycle while a reading
// is queued and the receiver keeps out_ready high; the sequencer in the back end sets the
// sustained rate. The front end extracts the digits with one divide-by-ten per cycle, and a
// two-entry queue lets it take the next reading while the back end still emits. The address
// register resets to 0x78 and is written through the configuration channel, which is always ready.
`default_nettype none

module decimal_reading_oled_renderer (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] reading,
  input  wire  [7:0]  start_column,
  input  wire  [3:0]  page,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        is_data,
  output logic [3:0]  byte_count,
  output logic [7:0]  byte_zero,
  output logic [7:0]  byte_one,
  output logic [7:0]  byte_two,
  output logic [7:0]  byte_three,
  output logic [7:0]  byte_four,
  output logic [7:0]  byte_five,
  output logic [7:0]  byte_six,
  output logic [7:0]  byte_seven,
  output logic        last
);

  logic           address;
  logic [7:0]     display_address_byte;
  logic           push, push_ready, head_valid, pop;
  dro_pkg::job_t  push_job, head_job;

  // Address register.
  assign cfg_ready = 1'b1;
  assign address   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_address_byte <= dro_pkg::ADDR_RESET;
    end else if (address) begin
      display_address_byte <= cfg_data;
    end
  end

  dro_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .reading      (reading),
    .start_column (start_column),
    .page         (page),
    .push         (push),
    .push_job     (push_job),
    .push_ready   (push_ready)
  );

  dro_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  dro_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .address    (display_address_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_data    (is_data),
    .byte_count (byte_count),
    .byte_zero  (byte_zero),
    .byte_one   (byte_one),
    .byte_two   (byte_two),
    .byte_three (byte_three),
    .byte_four  (byte_four),
    .byte_five  (byte_five),
    .byte_six   (byte_six),
    .byte_seven (byte_seven),
    .last       (last)
  );

endmodule

`default_nettype wire

// File: bench/decimal_reading_oled_renderer_test.sv
// Self-checking testbench for the decimal reading OLED renderer.
`timescale 1ns / 1ps

module decimal_reading_oled_renderer_test;

  localparam int CYCLE_LIMIT      = 250000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int PHASE_TOTAL      = 4;
  localparam int TXN_PER_READING  = 2 * dro_pkg::GLYPH_COUNT;
  localparam int DIRECTED_ROWS    = 18;
  localparam int SETTLE_CYCLES    = 20;

  // One I2C transaction as it leaves the block.
  typedef struct packed {
    logic       is_data;
    logic [3:0] byte_count;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [7:0] byte_five;
    logic [7:0] byte_six;
    logic [7:0] byte_seven;
    logic       last;
  } transaction_t;

  // A directed request; where typed is set, the first cursor transaction is written out by hand.
  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  column;
    logic [3:0]  pg;
    logic        typed;
    logic [7:0]  addr;
    logic [7:0]  col_lo;
    logic [7:0]  col_hi;
    logic [7:0]  page_cmd;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] reading;
  logic [7:0]  start_column;
  logic [3:0]  page;
  logic        out_valid;
  logic        out_ready;
  logic        is_data;
  logic [3:0]  byte_count;
  logic [7:0]  byte_zero;
  logic [7:0]  byte_one;
  logic [7:0]  byte_two;
  logic [7:0]  byte_three;
  logic [7:0]  byte_four;
  logic [7:0]  byte_five;
  logic [7:0]  byte_six;
  logic [7:0]  byte_seven;
  logic        last;

  transaction_t  pending_transactions [$];
  transaction_t  oldest;
  directed_row_t directed_table [DIRECTED_ROWS];
  logic [7:0]    address_byte;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  decimal_reading_oled_renderer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .reading      (reading),
    .start_column (start_column),
    .page         (page),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_data      (is_data),
    .byte_count   (byte_count),
    .byte_zero    (byte_zero),
    .byte_one     (byte_one),
    .byte_two     (byte_two),
    .byte_three   (byte_three),
    .byte_four    (byte_four),
    .byte_five    (byte_five),
    .byte_six     (byte_six),
    .byte_seven   (byte_seven),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Six font columns of each glyph, leftmost column in the top byte.
  function automatic logic [47:0] font_columns(input logic [3:0] glyph);
    logic [47:0] cols;
    case (glyph)
      4'd0:                   cols = 48'h3E_51_49_45_3E_00;
      4'd1:                   cols = 48'h00_42_7F_40_00_00;
      4'd2:                   cols = 48'h72_49_49_49_46_00;
      4'd3:                   cols = 48'h21_41_49_4D_33_00;
      4'd4:                   cols = 48'h18_14_12_7F_10_00;
      4'd5:                   cols = 48'h27_45_45_45_39_00;
      4'd6:                   cols = 48'h3C_4A_49_49_31_00;
      4'd7:                   cols = 48'h41_21_11_09_07_00;
      4'd8:                   cols = 48'h36_49_49_49_36_00;
      4'd9:                   cols = 48'h46_49_49_29_1E_00;
      dro_pkg::GLYPH_DEGREE:  cols = 48'h00_06_09_06_00_00;
      dro_pkg::GLYPH_CELSIUS: cols = 48'h3E_41_41_41_22_00;
      default:                cols = 48'h0;
    endcase
    return cols;
  endfunction

  // Queues the cursor and data transactions that draw one reading.
  function automatic void render_reading(input logic [15:0] value, input logic [7:0] column,
                                         input logic [3:0] pg);
    int unsigned  divisor;
    int           g;
    logic [7:0]   col;
    logic [3:0]   glyph;
    logic [47:0]  cols;
    transaction_t txn;
    divisor = 1;
    for (g = 1; g < dro_pkg::DIGIT_COUNT; g++) divisor = divisor * 10;
    col = column;
    for (g = 0; g < dro_pkg::GLYPH_COUNT; g++) begin
      if (g < dro_pkg::DIGIT_COUNT) begin
        glyph = 4'((value / divisor) % 10);
        divisor = (divisor > 1) ? divisor / 10 : 1;
      end else if (g == dro_pkg::DIGIT_COUNT) begin
        glyph = dro_pkg::GLYPH_DEGREE;
      end else begin
        glyph = dro_pkg::GLYPH_CELSIUS;
      end
      // Cursor: column nibbles and page, the top three bytes stay zero.
      txn = '0;
      txn.byte_count = dro_pkg::COUNT_CURSOR;
      txn.byte_zero  = address_byte;
      txn.byte_one   = dro_pkg::CTRL_CMD;
      txn.byte_two   = {4'h0, col[3:0]};
      txn.byte_three = dro_pkg::CMD_COL_HI | {4'h0, col[7:4]};
      txn.byte_four  = dro_pkg::CMD_PAGE | {4'h0, pg};
      pending_transactions.push_back(txn);
      // Data: the six font columns of the glyph.
      cols = font_columns(glyph);
      txn.is_data    = 1'b1;
      txn.byte_count = dro_pkg::COUNT_DATA;
      txn.byte_one   = dro_pkg::CTRL_DATA;
      {txn.byte_two, txn.byte_three, txn.byte_four,
       txn.byte_five, txn.byte_six, txn.byte_seven} = cols;
      txn.last       = (g == dro_pkg::GLYPH_COUNT - 1);
      pending_transactions.push_back(txn);
      col = col + 8'd8;
    end
  endfunction

  function automatic logic [15:0] pick_reading();
    int unsigned kind;
    logic [15:0] base;
    kind = $urandom_range(99);
    if (kind < 40) begin
      return 16'($urandom);
    end else if (kind < 70) begin
      return 16'($urandom_range(9999));
    end else if (kind < 85) begin
      // Close to a power of ten or to the top of the range.
      case ($urandom_range(4))
        0:       base = 16'd10;
        1:       base = 16'd100;
        2:       base = 16'd1000;
        3:       base = 16'd10000;
        default: base = 16'd65533;
      endcase
      return base + 16'($urandom_range(4)) - 16'd2;
    end else begin
      return 16'($urandom_range(9) * 1111);
    end
  endfunction

  // Presents one request, with random idle cycles ahead of it, and predicts it on acceptance.
  task automatic send_reading(input logic [15:0] value, input logic [7:0] column,
                              input logic [3:0] pg);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid     <= 1'b0;
      reading      <= 16'($urandom);
      start_column <= 8'($urandom);
      page         <= 4'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    reading      <= value;
    start_column <= column;
    page         <= pg;
    do @(posedge clk); while (!in_ready);
    render_reading(value, column, pg);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_transactions.size() != 0) @(posedge clk);
  endtask

  // The address register is only written once the block has gone quiet.
  task automatic write_address(input logic [7:0] value);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    address_byte = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every transaction taken from the block is held against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_transactions.size() == 0) begin
        $error("unexpected transaction: is_data %0d last %0d", is_data, last);
        mismatch_count++;
      end else begin
        oldest = pending_transactions.pop_front();
        check_field("is_data", oldest.is_data, is_data);
        check_field("byte_count", oldest.byte_count, byte_count);
        check_field("byte_zero", oldest.byte_zero, byte_zero);
        check_field("byte_one", oldest.byte_one, byte_one);
        check_field("byte_two", oldest.byte_two, byte_two);
        check_field("byte_three", oldest.byte_three, byte_three);
        check_field("byte_four", oldest.byte_four, byte_four);
        check_field("byte_five", oldest.byte_five, byte_five);
        check_field("byte_six", oldest.byte_six, byte_six);
        check_field("byte_seven", oldest.byte_seven, byte_seven);
        check_field("last", oldest.last, last);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("decimal_reading_oled_renderer_test: done, errors");
      $finish;
    end
  end

  initial begin
    transaction_t typed_cursor;
    int           row;
    int           phase;
    int           n;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = 8'h00;
    in_valid     = 1'b0;
    reading      = 16'h0;
    start_column = 8'h0;
    page         = 4'h0;
    out_ready    = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    address_byte = dro_pkg::ADDR_RESET;

    // Extremes of every field, column wrap, high columns and readings too wide to show.
    directed_table = '{
      {16'd0,     8'd0,   4'd0,  1'b1, 8'h78, 8'h00, 8'h10, 8'hB0},
      {16'd65535, 8'd255, 4'd15, 1'b1, 8'h78, 8'h0F, 8'h1F, 8'hBF},
      {16'd9999,  8'd248, 4'd7,  1'b1, 8'h78, 8'h08, 8'h1F, 8'hB7},
      {16'd10000, 8'd8,   4'd1,  1'b1, 8'h78, 8'h08, 8'h10, 8'hB1},
      {16'd1234,  8'd128, 4'd2,  1'b1, 8'h78, 8'h00, 8'h18, 8'hB2},
      {16'd5678,  8'd127, 4'd3,  1'b1, 8'h78, 8'h0F, 8'h17, 8'hB3},
      {16'd9090,  8'd16,  4'd4,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd1,     8'd200, 4'd15, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd10,    8'd232, 4'd0,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd100,   8'd64,  4'd8,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd999,   8'd247, 4'd5,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd32768, 8'd96,  4'd10, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd43210, 8'd160, 4'd12, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd54321, 8'd240, 4'd14, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd12345, 8'd1,   4'd6,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd60000, 8'd170, 4'd9,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd7,     8'd85,  4'd11, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      {16'd20000, 8'd250, 4'd13, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset address, with no idling on either side.
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_reading(directed_table[row].value, directed_table[row].column,
                   directed_table[row].pg);
      if (directed_table[row].typed) begin
        typed_cursor            = '0;
        typed_cursor.byte_count = 4'd5;
        typed_cursor.byte_zero  = directed_table[row].addr;
        typed_cursor.byte_two   = directed_table[row].col_lo;
        typed_cursor.byte_three = directed_table[row].col_hi;
        typed_cursor.byte_four  = directed_table[row].page_cmd;
        pending_transactions[pending_transactions.size() - TXN_PER_READING] = typed_cursor;
      end
    end
    stop_sending();

    // Random part: one address setting and one idling pattern per phase.
    for (phase = 0; phase < PHASE_TOTAL; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          write_address(8'h00);
        end
        1: begin
          idle_pct  = 52;
          stall_pct = 0;
          write_address(8'hFF);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 52;
          write_address(8'($urandom));
        end
        default: begin
          idle_pct  = 24;
          stall_pct = 24;
          write_address(8'h3C);
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Halfway through the second phase the sender holds off until the block has drained.
        if (phase == 1 && n == RANDOM_PER_PHASE / 2) begin
          stop_sending();
          wait_for_drain();
        end
        send_reading(pick_reading(),
                     ($urandom_range(99) < 25) ? 8'($urandom_range(255, 200)) : 8'($urandom),
                     4'($urandom));
      end
      stop_sending();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("decimal_reading_oled_renderer_test: done, clean");
    end else begin
      $display("decimal_reading_oled_renderer_test: done, errors");
    end
    $finish;
  end

endmodule
